>>> hw/rtl/collision_record_filter_macros.svh
`ifndef COLLISION_RECORD_FILTER_MACROS_SVH
`define COLLISION_RECORD_FILTER_MACROS_SVH
// assertion helpers, sampled on clk and quiet while arst_n is low
`ifndef NO_ASSERTIONS
`define CRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRF_ASSERT_IMP(lbl, ante, cons, msg)
`define CRF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/crf_pkg.sv
package crf_pkg;

	localparam int MAX_IDS_DEF = 1024;

	localparam int HDR_LEN      = 12;
	localparam int RCNT_LO_IDX  = 6;
	localparam int RCNT_HI_IDX  = 7;
	localparam int ZERO_FROM    = 8;
	localparam int REC_HDR_LEN  = 8;
	localparam int SPHERE_BYTES = 16;
	localparam int BOX_BYTES    = 24;
	localparam int FACE_BYTES   = 36;
	localparam int BODY_W       = 23;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_BYTE  = 2'd2,
		CMD_END   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_COUNT = 2'd1,
		KIND_FULL  = 2'd2
	} kind_e;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_RECORD  = 2'd1,
		PH_BODY    = 2'd2,
		PH_TRAILER = 2'd3
	} phase_e;

	// commands from the controller to the datapath
	typedef enum logic [2:0] {
		DP_NOP     = 3'd0,
		DP_TAKE    = 3'd1,
		DP_SEARCH  = 3'd2,
		DP_EMIT_LO = 3'd3,
		DP_EMIT_HI = 3'd4
	} dp_op_e;

	typedef struct packed {
		logic slot_free;
		logic need_search;
		logic srch_done;
		logic srch_hit;
	} sts_t;

endpackage

>>> hw/rtl/crf_ifs.sv
interface crf_in_if import crf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] model_id;
	logic [7:0]  data_byte;

	modport source (output valid, command, model_id, data_byte, input ready);
	modport sink (input valid, command, model_id, data_byte, output ready);
endinterface

interface crf_out_if import crf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] kept_count;
	logic        last_of_run;

	modport source (output valid, kind, out_byte, kept_count, last_of_run, input ready);
	modport sink (input valid, kind, out_byte, kept_count, last_of_run, output ready);
endinterface

>>> hw/rtl/collision_record_filter.sv
// channel  | dir | fields                                      | handshake
// in_ch    | in  | command, model_id, data_byte                | valid/ready
// out_ch   | out | kind, out_byte, kept_count, last_of_run     | valid/ready
//
// one beat per unstalled cycle for clear, add, end and all stream bytes but one per record
// the second id byte of a record holds the input for the list search: a walk over the
// single read port of the id ram, then both id bytes go out if kept
// a one-entry output register takes each result; input stalls if full or in search or emit
// arst_n clears list count, parser and output valid; the id ram needs no clearing
module collision_record_filter import crf_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	crf_in_if.sink   in_ch,
	crf_out_if.source out_ch
);

	dp_op_e op;
	sts_t   sts;
	logic   in_ready;

	crf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.sts     (sts),
		.in_ready(in_ready),
		.op      (op)
	);

	crf_datapath #(
		.MAX_IDS(MAX_IDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.command    (in_ch.command),
		.model_id   (in_ch.model_id),
		.data_byte  (in_ch.data_byte),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.kind       (out_ch.kind),
		.out_byte   (out_ch.out_byte),
		.kept_count (out_ch.kept_count),
		.last_of_run(out_ch.last_of_run),
		.sts        (sts)
	);

	assign in_ch.ready = in_ready;

endmodule

>>> hw/rtl/crf_ram.sv
module crf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/crf_ctrl.sv
module crf_ctrl import crf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  sts_t   sts,
	output logic   in_ready,
	output dp_op_e op
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT_LO,
		ST_EMIT_HI
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && sts.slot_free;

	always_comb begin
		op = DP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.slot_free) op = DP_TAKE;
			end
			ST_SEARCH: begin
				op = DP_SEARCH;
			end
			ST_EMIT_LO: begin
				if (sts.slot_free) op = DP_EMIT_LO;
			end
			ST_EMIT_HI: begin
				if (sts.slot_free) op = DP_EMIT_HI;
			end
			default: begin
				op = DP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op == DP_TAKE && sts.need_search) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (sts.srch_done) state_q <= sts.srch_hit ? ST_EMIT_LO : ST_IDLE;
				end
				ST_EMIT_LO: begin
					if (sts.slot_free) state_q <= ST_EMIT_HI;
				end
				ST_EMIT_HI: begin
					if (sts.slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/crf_datapath.sv
`include "collision_record_filter_macros.svh"

module crf_datapath import crf_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_e      op,
	input  logic [1:0]  command,
	input  logic [15:0] model_id,
	input  logic [7:0]  data_byte,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] kept_count,
	output logic        last_of_run,
	output sts_t        sts
);

	localparam int CW = $clog2(MAX_IDS + 1);
	localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

	// id list
	logic [CW-1:0] id_count_q;
	logic          list_full;
	logic          ram_we;
	logic          ram_re;
	logic [15:0]   ram_rdata;

	// parser
	phase_e            phase_q, phase_n;
	logic [3:0]        bidx_q, bidx_n;
	logic [15:0]       rtot_q, rtot_n;
	logic [15:0]       rseen_q, rseen_n;
	logic [7:0]        first_q, first_n;
	logic              keep_q;
	logic [15:0]       pc_q [3];
	logic [15:0]       pc_n [3];
	logic [BODY_W-1:0] brem_q, brem_n;
	logic [BODY_W-1:0] body_len;
	logic [15:0]       kept_q;
	logic [15:0]       sid_q, sid_n;
	logic [1:0]        part_k;
	logic              emit;
	logic [7:0]        ebyte;

	// search
	logic [CW-1:0] sidx_q;
	logic          spend_q;
	logic          srch_issue;
	logic          srch_hit;
	logic          srch_done;

	// output slot
	logic        out_valid_q;
	kind_e       out_kind_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_cnt_q;
	logic        out_last_q;
	logic        slot_load;
	kind_e       ld_kind;
	logic [7:0]  ld_byte;
	logic [15:0] ld_cnt;
	logic        ld_last;

	assign list_full = (id_count_q == CW'(MAX_IDS));
	assign ram_we    = (op == DP_TAKE) && (cmd_e'(command) == CMD_ADD) && !list_full;

	assign srch_issue = (op == DP_SEARCH) && (sidx_q < id_count_q);
	assign ram_re     = srch_issue;
	assign srch_hit   = spend_q && (ram_rdata == sid_q);
	assign srch_done  = srch_hit || (!spend_q && (sidx_q >= id_count_q));

	crf_ram #(
		.WIDTH(16),
		.DEPTH(MAX_IDS)
	) u_id_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(id_count_q[AW-1:0]),
		.wdata(model_id),
		.re   (ram_re),
		.raddr(sidx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign part_k = 2'((bidx_q - 4'd2) >> 1);

	// next parser state for one stream byte
	always_comb begin
		phase_n  = phase_q;
		bidx_n   = bidx_q;
		rtot_n   = rtot_q;
		rseen_n  = rseen_q;
		first_n  = first_q;
		pc_n     = pc_q;
		brem_n   = brem_q;
		sid_n    = sid_q;
		emit     = 1'b0;
		ebyte    = data_byte;
		body_len = '0;
		case (phase_q)
			PH_HEADER: begin
				if (bidx_q == 4'(RCNT_LO_IDX)) rtot_n = {8'h00, data_byte};
				if (bidx_q == 4'(RCNT_HI_IDX)) rtot_n = {data_byte, rtot_q[7:0]};
				emit = 1'b1;
				if (bidx_q >= 4'(ZERO_FROM)) ebyte = 8'h00;
				if (bidx_q == 4'(HDR_LEN - 1)) begin
					bidx_n  = '0;
					rseen_n = '0;
					phase_n = (rtot_n == '0) ? PH_TRAILER : PH_RECORD;
				end else begin
					bidx_n = bidx_q + 4'd1;
				end
			end
			PH_RECORD: begin
				if (bidx_q == 4'd0) begin
					first_n = data_byte;
				end else if (bidx_q == 4'd1) begin
					sid_n = {data_byte, first_q};
				end else begin
					if (!bidx_q[0]) pc_n[part_k] = {8'h00, data_byte};
					else pc_n[part_k] = {data_byte, pc_q[part_k][7:0]};
					emit = keep_q;
				end
				if (bidx_q == 4'(REC_HDR_LEN - 1)) begin
					body_len = BODY_W'(pc_n[0]) * BODY_W'(SPHERE_BYTES)
						+ BODY_W'(pc_n[1]) * BODY_W'(BOX_BYTES)
						+ BODY_W'(pc_n[2]) * BODY_W'(FACE_BYTES);
					bidx_n = '0;
					brem_n = body_len;
					if (body_len == '0) begin
						rseen_n = rseen_q + 16'd1;
						phase_n = (rseen_n >= rtot_q) ? PH_TRAILER : PH_RECORD;
					end else begin
						phase_n = PH_BODY;
					end
				end else begin
					bidx_n = bidx_q + 4'd1;
				end
			end
			PH_BODY: begin
				emit   = keep_q;
				brem_n = brem_q - BODY_W'(1);
				if (brem_q == BODY_W'(1)) begin
					bidx_n  = '0;
					rseen_n = rseen_q + 16'd1;
					phase_n = (rseen_n >= rtot_q) ? PH_TRAILER : PH_RECORD;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// what goes into the output slot this cycle
	always_comb begin
		slot_load = 1'b0;
		ld_kind   = KIND_BYTE;
		ld_byte   = 8'h00;
		ld_cnt    = 16'h0000;
		ld_last   = 1'b1;
		case (op)
			DP_TAKE: begin
				case (cmd_e'(command))
					CMD_ADD: begin
						slot_load = list_full;
						ld_kind   = KIND_FULL;
					end
					CMD_BYTE: begin
						slot_load = emit;
						ld_byte   = ebyte;
					end
					CMD_END: begin
						slot_load = 1'b1;
						ld_kind   = KIND_COUNT;
						ld_cnt    = kept_q;
					end
					default: begin
						slot_load = 1'b0;
					end
				endcase
			end
			DP_EMIT_LO: begin
				slot_load = 1'b1;
				ld_byte   = sid_q[7:0];
				ld_last   = 1'b0;
			end
			DP_EMIT_HI: begin
				slot_load = 1'b1;
				ld_byte   = sid_q[15:8];
			end
			default: begin
				slot_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_count_q <= '0;
			phase_q    <= PH_HEADER;
			bidx_q     <= '0;
			rtot_q     <= '0;
			rseen_q    <= '0;
			first_q    <= '0;
			keep_q     <= 1'b1;
			pc_q       <= '{default: '0};
			brem_q     <= '0;
			kept_q     <= '0;
			sidx_q     <= '0;
			spend_q    <= 1'b0;
		end else begin
			case (op)
				DP_TAKE: begin
					case (cmd_e'(command))
						CMD_CLEAR, CMD_END: begin
							if (cmd_e'(command) == CMD_CLEAR) id_count_q <= '0;
							phase_q <= PH_HEADER;
							bidx_q  <= '0;
							rtot_q  <= '0;
							rseen_q <= '0;
							first_q <= '0;
							keep_q  <= 1'b1;
							pc_q    <= '{default: '0};
							brem_q  <= '0;
							kept_q  <= '0;
						end
						CMD_ADD: begin
							if (!list_full) id_count_q <= id_count_q + CW'(1);
						end
						default: begin
							phase_q <= phase_n;
							bidx_q  <= bidx_n;
							rtot_q  <= rtot_n;
							rseen_q <= rseen_n;
							first_q <= first_n;
							pc_q    <= pc_n;
							brem_q  <= brem_n;
							if (sts.need_search) begin
								sidx_q  <= '0;
								spend_q <= 1'b0;
							end
						end
					endcase
				end
				DP_SEARCH: begin
					if (srch_issue) sidx_q <= sidx_q + CW'(1);
					spend_q <= srch_issue;
					if (srch_done) begin
						keep_q <= srch_hit;
						if (srch_hit) kept_q <= kept_q + 16'd1;
					end
				end
				default: begin
					spend_q <= spend_q;
				end
			endcase
		end
	end

	// search id has no reset, it is only read after a load
	always_ff @(posedge clk) begin
		if (op == DP_TAKE && sts.need_search) sid_q <= sid_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_load) begin
			out_kind_q <= ld_kind;
			out_byte_q <= ld_byte;
			out_cnt_q  <= ld_cnt;
			out_last_q <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign out_byte    = out_byte_q;
	assign kept_count  = out_cnt_q;
	assign last_of_run = out_last_q;

	assign sts.slot_free   = !out_valid_q || out_ready;
	assign sts.need_search = (cmd_e'(command) == CMD_BYTE) && (phase_q == PH_RECORD)
		&& (bidx_q == 4'd1);
	assign sts.srch_done   = srch_done;
	assign sts.srch_hit    = srch_hit;

	`CRF_ASSERT_IMP(a_slot_overrun, slot_load, !out_valid_q || out_ready, "output slot overwritten")
	`CRF_ASSERT_IMP(a_count_bound, 1'b1, id_count_q <= CW'(MAX_IDS), "id count past list size")
	`CRF_ASSERT_IMP(a_body_len, phase_q == PH_BODY, brem_q != '0, "body phase with nothing left")
	`CRF_ASSERT_NXT(a_search_init, op == DP_TAKE && sts.need_search, sidx_q == '0 && !spend_q, "search not rewound")

endmodule

>>> bench/collision_record_filter_tb.sv
module collision_record_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import crf_pkg::*;

	typedef struct packed {
		kind_e       kind;
		logic [7:0]  out_byte;
		logic [15:0] kept_count;
		logic        last_of_run;
	} beat_t;

	typedef struct {
		cmd_e        cmd;
		logic [15:0] id;
		logic [7:0]  data;
		bit          lit;
		beat_t       want;
	} row_t;

	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 400;
	localparam int N_SCRIPT     = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	crf_in_if  in_ch ();
	crf_out_if out_ch ();

	collision_record_filter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lit rows carry a result that is plain from the format; the rest go through the predictor
	row_t script [N_SCRIPT] = '{
		'{CMD_END,   16'h0000, 8'h00, 1'b1, '{KIND_COUNT, 8'h00, 16'h0000, 1'b1}},
		'{CMD_ADD,   16'hFFFF, 8'hFF, 1'b0, '0},
		'{CMD_ADD,   16'h0000, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'hFFFF, 8'hFF, 1'b1, '{KIND_BYTE, 8'hFF, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'h0000, 8'h00, 1'b1, '{KIND_BYTE, 8'h00, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'hA5A5, 8'h5A, 1'b0, '0},
		'{CMD_BYTE,  16'h5A5A, 8'hA5, 1'b0, '0},
		'{CMD_BYTE,  16'h0000, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'hFFFF, 8'hFF, 1'b0, '0},
		'{CMD_BYTE,  16'h1234, 8'h01, 1'b0, '0},
		'{CMD_BYTE,  16'h8001, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'h0000, 8'hFF, 1'b1, '{KIND_BYTE, 8'h00, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'hFFFF, 8'hFF, 1'b1, '{KIND_BYTE, 8'h00, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'h00FF, 8'h80, 1'b1, '{KIND_BYTE, 8'h00, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'hFF00, 8'h7F, 1'b1, '{KIND_BYTE, 8'h00, 16'h0000, 1'b1}},
		'{CMD_BYTE,  16'h0F0F, 8'hFF, 1'b0, '0},
		'{CMD_BYTE,  16'hF0F0, 8'hFF, 1'b0, '0},
		'{CMD_BYTE,  16'h0000, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'hFFFF, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'h0000, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'hFFFF, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'h0000, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'hFFFF, 8'h00, 1'b0, '0},
		'{CMD_BYTE,  16'h3C3C, 8'hAB, 1'b0, '0},
		'{CMD_END,   16'hC3C3, 8'h54, 1'b0, '0},
		'{CMD_CLEAR, 16'hFFFF, 8'hFF, 1'b0, '0}
	};

	// predictor state
	logic [15:0] keep_ids [MAX_IDS_DEF];
	int unsigned n_ids;
	phase_e      ph;
	int unsigned idx;
	logic [15:0] rec_total;
	logic [15:0] rec_seen;
	logic [7:0]  id_lo;
	bit          keeping;
	logic [15:0] part_n [3];
	int unsigned body_left;
	logic [15:0] kept;
	beat_t       pred_out [2];
	int          pred_n;

	beat_t pending_results [$];
	int    errors;
	int    items_taken;
	int    src_idle_pct;
	int    snk_stall_pct;
	int    hold_gen;
	bit    beat_lit;
	beat_t beat_want;
	logic [15:0] listed [$];

	function automatic bit roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	task automatic restart_parser();
		ph = PH_HEADER;
		idx = 0;
		rec_total = '0;
		rec_seen = '0;
		id_lo = '0;
		keeping = 1'b1;
		part_n = '{default: '0};
		body_left = 0;
		kept = '0;
	endtask

	task automatic emit(input kind_e k, input logic [7:0] b, input logic [15:0] cnt,
			input logic last);
		pred_out[pred_n] = '{k, b, cnt, last};
		pred_n++;
	endtask

	task automatic close_record();
		rec_seen = rec_seen + 16'd1;
		idx = 0;
		ph = (rec_seen >= rec_total) ? PH_TRAILER : PH_RECORD;
	endtask

	task automatic filter_step(input cmd_e c, input logic [15:0] id, input logic [7:0] b);
		int unsigned k;
		bit hit;
		pred_n = 0;
		case (c)
			CMD_CLEAR: begin
				n_ids = 0;
				restart_parser();
			end
			CMD_ADD: begin
				if (n_ids >= MAX_IDS_DEF) begin
					emit(KIND_FULL, 8'h00, 16'h0000, 1'b1);
				end else begin
					keep_ids[n_ids] = id;
					n_ids++;
				end
			end
			CMD_BYTE: begin
				case (ph)
					PH_HEADER: begin
						if (idx == RCNT_LO_IDX) begin
							rec_total = {8'h00, b};
						end else if (idx == RCNT_HI_IDX) begin
							rec_total = rec_total | {b, 8'h00};
						end
						emit(KIND_BYTE, (idx >= ZERO_FROM) ? 8'h00 : b, 16'h0000, 1'b1);
						idx++;
						if (idx >= HDR_LEN) begin
							idx = 0;
							rec_seen = '0;
							ph = (rec_total == 0) ? PH_TRAILER : PH_RECORD;
						end
					end
					PH_RECORD: begin
						if (idx == 0) begin
							id_lo = b;
						end else if (idx == 1) begin
							hit = 1'b0;
							for (int i = 0; i < n_ids; i++) begin
								if (keep_ids[i] == {b, id_lo})
									hit = 1'b1;
							end
							keeping = hit;
							if (hit) begin
								kept = kept + 16'd1;
								emit(KIND_BYTE, id_lo, 16'h0000, 1'b0);
								emit(KIND_BYTE, b, 16'h0000, 1'b1);
							end
						end else begin
							// bytes 2..7 are the sphere, box and face counts, low byte first
							k = (idx - 2) >> 1;
							if (idx[0] == 1'b0)
								part_n[k] = {8'h00, b};
							else
								part_n[k] = part_n[k] | {b, 8'h00};
							if (keeping)
								emit(KIND_BYTE, b, 16'h0000, 1'b1);
						end
						idx++;
						if (idx >= REC_HDR_LEN) begin
							idx = 0;
							body_left = SPHERE_BYTES * part_n[0] + BOX_BYTES * part_n[1]
								+ FACE_BYTES * part_n[2];
							if (body_left == 0)
								close_record();
							else
								ph = PH_BODY;
						end
					end
					PH_BODY: begin
						if (keeping)
							emit(KIND_BYTE, b, 16'h0000, 1'b1);
						if (body_left > 0)
							body_left--;
						if (body_left == 0)
							close_record();
					end
					default: begin
					end
				endcase
			end
			default: begin
				emit(KIND_COUNT, 8'h00, kept, 1'b1);
				restart_parser();
			end
		endcase
	endtask

	always @(posedge clk) begin
		beat_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				filter_step(cmd_e'(in_ch.command), in_ch.model_id, in_ch.data_byte);
				if (beat_lit) begin
					pending_results.push_back(beat_want);
				end else begin
					for (int i = 0; i < pred_n; i++)
						pending_results.push_back(pred_out[i]);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result kind %0d byte %h count %h last %b",
						$time, out_ch.kind, out_ch.out_byte, out_ch.kept_count,
						out_ch.last_of_run);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (out_ch.kind !== want.kind || out_ch.out_byte !== want.out_byte ||
							out_ch.kept_count !== want.kept_count ||
							out_ch.last_of_run !== want.last_of_run) begin
						$display("%0t: expected kind %0d byte %h count %h last %b", $time,
							want.kind, want.out_byte, want.kept_count, want.last_of_run);
						$display("%0t: actual   kind %0d byte %h count %h last %b", $time,
							out_ch.kind, out_ch.out_byte, out_ch.kept_count,
							out_ch.last_of_run);
						errors++;
					end
				end
			end
		end
	end

	// receiver side, with a long hold-off whenever hold_gen moves
	initial begin
		int hold_left;
		int seen_gen;
		hold_left = 0;
		seen_gen = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_gen != seen_gen) begin
				seen_gen = hold_gen;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !roll(snk_stall_pct);
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_beat(input cmd_e c, input logic [15:0] id, input logic [7:0] b,
			input bit lit = 1'b0, input beat_t want = '0);
		while (roll(src_idle_pct)) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= c;
		in_ch.model_id <= id;
		in_ch.data_byte <= b;
		beat_lit <= lit;
		beat_want <= want;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		items_taken++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(CMD_BYTE, 16'($urandom), b);
	endtask

	task automatic send_cmd(input cmd_e c);
		send_beat(c, 16'($urandom), 8'($urandom));
	endtask

	task automatic add_id(input logic [15:0] id);
		send_beat(CMD_ADD, id, 8'($urandom));
		listed.push_back(id);
	endtask

	function automatic logic [15:0] pick_id();
		if (listed.size() > 0 && roll(60))
			return listed[$urandom_range(listed.size() - 1, 0)];
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] small_count();
		int r;
		r = $urandom_range(99, 0);
		return (r < 60) ? 16'd0 : (r < 95) ? 16'd1 : 16'd2;
	endfunction

	task automatic send_header(input logic [15:0] rc, input int upto);
		for (int i = 0; i < upto; i++)
			send_byte(i == RCNT_LO_IDX ? rc[7:0] : i == RCNT_HI_IDX ? rc[15:8] : 8'($urandom));
	endtask

	task automatic send_record(input logic [15:0] id, input logic [15:0] ns, input logic [15:0] nb,
			input logic [15:0] nf, input int upto);
		logic [7:0] head [REC_HDR_LEN];
		int body;
		head = '{id[7:0], id[15:8], ns[7:0], ns[15:8], nb[7:0], nb[15:8], nf[7:0], nf[15:8]};
		body = SPHERE_BYTES * ns + BOX_BYTES * nb + FACE_BYTES * nf;
		for (int i = 0; i < REC_HDR_LEN + body && i < upto; i++)
			send_byte(i < REC_HDR_LEN ? head[i] : 8'($urandom));
	endtask

	task automatic send_stream();
		int nrec;
		int claim;
		bit broken;
		nrec = roll(10) ? 0 : $urandom_range(4, 1);
		broken = roll(12);
		if (broken && roll(30)) begin
			// cut off inside the header
			send_header(16'($urandom), $urandom_range(HDR_LEN - 1, 0));
			send_cmd(CMD_END);
			return;
		end
		claim = nrec;
		if (broken)
			claim = roll(30) ? $urandom_range(65535, nrec + 1) : nrec + $urandom_range(3, 1);
		send_header(claim[15:0], HDR_LEN);
		for (int r = 0; r < nrec; r++) begin
			if (roll(5))
				add_id(16'($urandom));
			send_record(pick_id(), small_count(), small_count(), small_count(), 1 << 30);
		end
		if (broken) begin
			// end of stream inside a record, sometimes with a huge body pending
			if (roll(30))
				send_record(pick_id(), 16'($urandom), 16'($urandom), 16'($urandom),
					$urandom_range(30, 0));
			else
				send_record(pick_id(), small_count(), small_count(), small_count(),
					$urandom_range(40, 0));
		end else begin
			repeat ($urandom_range(3, 0))
				send_byte(8'($urandom));
		end
		send_cmd(CMD_END);
	endtask

	task automatic run_session();
		if (roll(10)) begin
			repeat ($urandom_range(20, 3))
				send_beat(cmd_e'($urandom_range(3, 0)), 16'($urandom), 8'($urandom));
			return;
		end
		send_cmd(CMD_CLEAR);
		listed.delete();
		repeat ($urandom_range(10, 0))
			add_id(roll(10) ? (roll(50) ? 16'hFFFF : 16'h0000) : 16'($urandom));
		repeat ($urandom_range(2, 1))
			send_stream();
	endtask

	initial begin
		int start;
		int mode;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_CLEAR;
		in_ch.model_id = '0;
		in_ch.data_byte = '0;
		beat_lit = 1'b0;
		beat_want = '0;
		errors = 0;
		items_taken = 0;
		hold_gen = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		n_ids = 0;
		restart_parser();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			send_beat(script[i].cmd, script[i].id, script[i].data, script[i].lit, script[i].want);

		start = items_taken;
		while (items_taken - start < RANDOM_ITEMS) begin
			mode = (items_taken - start) * 4 / RANDOM_ITEMS;
			case (mode)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 52;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 52;
				end
				default: begin
					src_idle_pct = 21;
					snk_stall_pct = 21;
				end
			endcase
			run_session();
		end

		// receiver holds off while a kept record keeps coming
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_cmd(CMD_CLEAR);
		listed.delete();
		add_id(16'h1234);
		hold_gen <= hold_gen + 1;
		send_header(16'd1, HDR_LEN);
		send_record(16'h1234, 16'd3, 16'd0, 16'd0, 1 << 30);
		send_cmd(CMD_END);

		// full id list: overflow adds, then searches over the whole list
		src_idle_pct = 21;
		snk_stall_pct = 21;
		send_cmd(CMD_CLEAR);
		listed.delete();
		repeat (MAX_IDS_DEF)
			add_id(16'($urandom));
		repeat (2)
			send_beat(CMD_ADD, 16'($urandom), 8'($urandom));
		repeat (2)
			send_stream();
		send_cmd(CMD_CLEAR);

		in_ch.valid <= 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
